>>> src/hmfop_pkg.sv
// ----------------------------------------------------------------------------
// hmfop_pkg: shared types and constants of the heart mask pixel block
// Fixed-point constants, controller command/status types and helpers.
// ----------------------------------------------------------------------------
package hmfop_pkg;

  // Geometry
  localparam int MAX_SIZE = 128;
  localparam int SS       = 4;                 // supersample factor per axis
  localparam int SS_W     = $clog2(SS);
  localparam int COORD_W  = 7;
  localparam int SIZE_W   = 8;
  localparam int HIT_W    = $clog2(SS * SS + 1);
  localparam int RAD_W    = 4;
  localparam int NB_W     = RAD_W + 1;

  // Fixed point, Q.24
  localparam int Q_FRAC = 24;
  localparam int Q_W    = 32;
  localparam int P_W    = 2 * Q_W;
  localparam logic signed [Q_W-1:0] Q_ONE = 32'sd16777216;
  localparam logic signed [Q_W-1:0] Q_SX  = 32'sd22481469;
  localparam logic signed [Q_W-1:0] Q_SY  = 32'sd21474836;
  localparam logic signed [Q_W-1:0] Q_OY  = 32'sd2348810;

  // Sample coordinate divider
  localparam int N_W       = COORD_W + SS_W + 1;   // 2*SS*p + 2*s + 1
  localparam int DVD_W     = N_W + Q_FRAC;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DSR_W     = SIZE_W + SS_W;        // SS * size
  localparam int QUO_W     = Q_FRAC + 2;

  // size / 13 as a reciprocal multiply, exact for sizes up to MAX_SIZE
  localparam int RAD_MUL   = 79;
  localparam int RAD_SHIFT = 10;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_MUL,
    DP_WB,
    DP_ADD_A,
    DP_HIT,
    DP_PIX_END,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [2:0] {
    M_X, M_Y, M_X2, M_Y2, M_AA, M_A3, M_XY, M_T
  } mul_step_e;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIVX_INIT, S_DIVX, S_NX, S_DIVY_INIT, S_DIVY, S_NY,
    S_MUL, S_WB, S_ADD_A, S_HIT, S_PIX_END, S_CHECK, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e    op;
    logic      axis_y;
    mul_step_e mstep;
  } dp_cmd_t;

  typedef struct packed {
    logic outside;
    logic samp_last;
    logic nb_done;
    logic out_free;
  } dp_stat_t;

  // Q.24 product truncated toward zero
  function automatic logic signed [Q_W-1:0] qtrunc(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] b;
    b = p + (p[P_W-1] ? P_W'((64'sd1 <<< Q_FRAC) - 64'sd1) : P_W'(0));
    return b[Q_FRAC+Q_W-1:Q_FRAC];
  endfunction

  // round(h * 255 / SS^2)
  function automatic logic [7:0] alpha_of(input logic [HIT_W-1:0] h);
    logic [15:0] t;
    t = 16'(h) * 16'(510) + 16'(SS * SS);
    return 8'(t / (2 * SS * SS));
  endfunction

  // max(1, size / 13)
  function automatic logic [RAD_W-1:0] radius_of(input logic [SIZE_W-1:0] s);
    logic [15:0] p;
    logic [RAD_W-1:0] r;
    p = 16'(s) * 16'(RAD_MUL);
    r = RAD_W'(p >> RAD_SHIFT);
    return (r == '0) ? RAD_W'(1) : r;
  endfunction

endpackage

>>> src/hmfop_if.sv
// ----------------------------------------------------------------------------
// hmfop_if: pixel and result channels
// Valid/ready channels carrying a pixel coordinate and its two alphas.
// ----------------------------------------------------------------------------
interface hmfop_pix_if;
  logic                            valid;
  logic                            ready;
  logic [hmfop_pkg::COORD_W-1:0]   pixel_x;
  logic [hmfop_pkg::COORD_W-1:0]   pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface hmfop_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] fill_alpha;
  logic [7:0] outline_alpha;
  logic       outside_mask;

  modport source (output valid, output fill_alpha, output outline_alpha,
                  output outside_mask, input ready);
  modport sink   (input valid, input fill_alpha, input outline_alpha,
                  input outside_mask, output ready);
endinterface

>>> src/hmfop_ctrl.sv
// ----------------------------------------------------------------------------
// hmfop_ctrl: sequencer of the heart mask pixel block
// Steps the datapath through division, multiply and neighbor passes.
// ----------------------------------------------------------------------------
module hmfop_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hmfop_pkg::dp_stat_t stat_i,
  output hmfop_pkg::dp_cmd_t  cmd_o
);
  import hmfop_pkg::*;

  ctrl_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  mul_step_e             k_q, k_d;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= M_X;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_START;
      S_START:     state_d = stat_i.outside ? S_DONE : S_DIVX_INIT;
      S_DIVX_INIT: begin
        cnt_d   = '0;
        state_d = S_DIVX;
      end
      S_DIVX: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_NX;
      end
      S_NX:        state_d = S_DIVY_INIT;
      S_DIVY_INIT: begin
        cnt_d   = '0;
        state_d = S_DIVY;
      end
      S_DIVY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_NY;
      end
      S_NY: begin
        k_d     = M_X;
        state_d = S_MUL;
      end
      S_MUL:       state_d = S_WB;
      S_WB: begin
        if (k_q == M_T) begin
          state_d = S_HIT;
        end else begin
          k_d     = mul_step_e'(k_q + 1'b1);
          state_d = (k_q == M_Y2) ? S_ADD_A : S_MUL;
        end
      end
      S_ADD_A:     state_d = S_MUL;
      S_HIT:       state_d = stat_i.samp_last ? S_PIX_END : S_DIVX_INIT;
      S_PIX_END:   state_d = S_CHECK;
      S_CHECK:     state_d = stat_i.nb_done ? S_DONE : S_DIVX_INIT;
      S_DONE:      if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op     = DP_NOP;
    cmd_o.axis_y = 1'b0;
    cmd_o.mstep  = k_q;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      S_DIVX_INIT: cmd_o.op = DP_DIV_INIT;
      S_DIVX:      cmd_o.op = DP_DIV_STEP;
      S_NX:        cmd_o.op = DP_DIV_END;
      S_DIVY_INIT: begin
        cmd_o.op     = DP_DIV_INIT;
        cmd_o.axis_y = 1'b1;
      end
      S_DIVY:      cmd_o.op = DP_DIV_STEP;
      S_NY: begin
        cmd_o.op     = DP_DIV_END;
        cmd_o.axis_y = 1'b1;
      end
      S_MUL:       cmd_o.op = DP_MUL;
      S_WB:        cmd_o.op = DP_WB;
      S_ADD_A:     cmd_o.op = DP_ADD_A;
      S_HIT:       cmd_o.op = DP_HIT;
      S_PIX_END:   cmd_o.op = DP_PIX_END;
      S_DONE:      if (stat_i.out_free) cmd_o.op = DP_FINISH;
      default:     cmd_o.op = DP_NOP;
    endcase
  end

endmodule

>>> src/hmfop_dp.sv
// ----------------------------------------------------------------------------
// hmfop_dp: datapath of the heart mask pixel block
// Divider, shared multiplier, hit counter, window minimum, output register.
// ----------------------------------------------------------------------------
module hmfop_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hmfop_pkg::dp_cmd_t            cmd_i,
  output hmfop_pkg::dp_stat_t           stat_o,
  input  logic [hmfop_pkg::COORD_W-1:0] pixel_x_i,
  input  logic [hmfop_pkg::COORD_W-1:0] pixel_y_i,
  input  logic                          cfg_we_i,
  input  logic [hmfop_pkg::SIZE_W-1:0]  cfg_data_i,
  hmfop_res_if.source                   res_o
);
  import hmfop_pkg::*;

  // Configuration
  logic [SIZE_W-1:0] mask_size_q;
  logic [SIZE_W-1:0] size_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_size_q <= SIZE_W'(48);
    else if (cfg_we_i) mask_size_q <= cfg_data_i;
  end

  assign size_eff = (mask_size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : mask_size_q;

  // Item and iteration registers
  logic [COORD_W-1:0] px_q, py_q, cur_x_q, cur_y_q;
  logic [SIZE_W-1:0]  size_q;
  logic [RAD_W-1:0]   r_q;
  logic [NB_W-1:0]    dxc_q, dyc_q;
  logic [SS_W-1:0]    sx_q, sy_q;
  logic [HIT_W-1:0]   hits_q, c_q, mn_q;
  logic               outside_q, center_q, nb_done_q;

  // Divider registers
  logic [DVD_W-1:0]   dvd_q;
  logic [DSR_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [DSR_W:0]     rem_t;
  logic [DSR_W-1:0]   dsr;
  logic [N_W-1:0]     num;

  // Curve registers
  logic signed [Q_W-1:0] nx_q, ny_q, x_q, y_q, x2_q, y2_q, a_q, aa_q, a3_q, xy_q, t_q;
  logic signed [Q_W-1:0] op_a, op_b, tr;
  logic signed [P_W-1:0] prod_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] fill_q, outl_q;
  logic       omask_q;

  // Window helpers
  logic [SIZE_W-1:0]  px_e, py_e, r_e;
  logic               win_inside;
  logic [HIT_W-1:0]   mn_new;
  logic [NB_W-1:0]    span;

  assign px_e = SIZE_W'(px_q);
  assign py_e = SIZE_W'(py_q);
  assign r_e  = SIZE_W'(r_q);
  assign win_inside = (px_e >= r_e) && (py_e >= r_e) &&
                      (px_e + r_e < size_q) && (py_e + r_e < size_q);
  assign mn_new = (hits_q < mn_q) ? hits_q : mn_q;
  assign span   = {r_q, 1'b0};

  // Divider numerator 2*SS*p + 2*s + 1 and divisor SS*size
  assign num   = cmd_i.axis_y ? {cur_y_q, sy_q, 1'b1} : {cur_x_q, sx_q, 1'b1};
  assign dsr   = {size_q, {SS_W{1'b0}}};
  assign rem_t = {rem_q, dvd_q[DVD_W-1]};

  // Multiplier operand select
  always_comb begin
    case (cmd_i.mstep)
      M_X:     begin op_a = nx_q; op_b = Q_SX; end
      M_Y:     begin op_a = ny_q; op_b = Q_SY; end
      M_X2:    begin op_a = x_q;  op_b = x_q;  end
      M_Y2:    begin op_a = y_q;  op_b = y_q;  end
      M_AA:    begin op_a = a_q;  op_b = a_q;  end
      M_A3:    begin op_a = aa_q; op_b = a_q;  end
      M_XY:    begin op_a = x2_q; op_b = y2_q; end
      M_T:     begin op_a = xy_q; op_b = y_q;  end
      default: begin op_a = '0;   op_b = '0;   end
    endcase
  end

  assign tr = qtrunc(prod_q);

  // Payload registers: divider, multiplier and curve values
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_DIV_INIT: begin
        dvd_q <= {num, {Q_FRAC{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
      end
      DP_DIV_STEP: begin
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        if (rem_t >= {1'b0, dsr}) begin
          rem_q <= DSR_W'(rem_t - {1'b0, dsr});
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_t[DSR_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      DP_DIV_END: begin
        if (cmd_i.axis_y) ny_q <= $signed(Q_W'(quo_q)) - Q_ONE;
        else nx_q <= $signed(Q_W'(quo_q)) - Q_ONE;
      end
      DP_MUL:   prod_q <= op_a * op_b;
      DP_WB: begin
        case (cmd_i.mstep)
          M_X:     x_q  <= tr;
          M_Y:     y_q  <= Q_OY - tr;
          M_X2:    x2_q <= tr;
          M_Y2:    y2_q <= tr;
          M_AA:    aa_q <= tr;
          M_A3:    a3_q <= tr;
          M_XY:    xy_q <= tr;
          M_T:     t_q  <= tr;
          default: t_q  <= tr;
        endcase
      end
      DP_ADD_A: a_q <= x2_q + y2_q - Q_ONE;
      default:  ;
    endcase
  end

  // Item, sample and neighbor control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; cur_x_q <= '0; cur_y_q <= '0;
      size_q <= '0; r_q <= '0; dxc_q <= '0; dyc_q <= '0;
      sx_q <= '0; sy_q <= '0; hits_q <= '0; c_q <= '0; mn_q <= '0;
      outside_q <= 1'b0; center_q <= 1'b0; nb_done_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_LOAD: begin
          px_q      <= pixel_x_i;
          py_q      <= pixel_y_i;
          cur_x_q   <= pixel_x_i;
          cur_y_q   <= pixel_y_i;
          size_q    <= size_eff;
          r_q       <= radius_of(size_eff);
          outside_q <= (SIZE_W'(pixel_x_i) >= size_eff) || (SIZE_W'(pixel_y_i) >= size_eff);
          sx_q      <= '0;
          sy_q      <= '0;
          hits_q    <= '0;
          center_q  <= 1'b1;
          nb_done_q <= 1'b0;
        end
        DP_HIT: begin
          hits_q <= hits_q + HIT_W'(a3_q < t_q);
          sx_q   <= sx_q + 1'b1;
          if (sx_q == SS_W'(SS - 1)) sy_q <= sy_q + 1'b1;
        end
        DP_PIX_END: begin
          hits_q <= '0;
          sx_q   <= '0;
          sy_q   <= '0;
          if (center_q) begin
            // Center done: any off-image neighbor forces the minimum to zero
            c_q      <= hits_q;
            center_q <= 1'b0;
            mn_q     <= win_inside ? hits_q : '0;
            if (!win_inside || hits_q == '0) begin
              nb_done_q <= 1'b1;
            end else begin
              cur_x_q <= px_q - COORD_W'(r_q);
              cur_y_q <= py_q - COORD_W'(r_q);
              dxc_q   <= '0;
              dyc_q   <= '0;
            end
          end else begin
            mn_q <= mn_new;
            if (mn_new == '0 || (dxc_q == span && dyc_q == span)) begin
              nb_done_q <= 1'b1;
            end else if (dxc_q == span) begin
              dxc_q   <= '0;
              dyc_q   <= dyc_q + 1'b1;
              cur_x_q <= px_q - COORD_W'(r_q);
              cur_y_q <= cur_y_q + 1'b1;
            end else begin
              dxc_q   <= dxc_q + 1'b1;
              cur_x_q <= cur_x_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_FINISH) begin
      omask_q <= outside_q;
      fill_q  <= outside_q ? 8'd0 : alpha_of(c_q);
      outl_q  <= outside_q ? 8'd0 : alpha_of(c_q - mn_q);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.fill_alpha    = fill_q;
  assign res_o.outline_alpha = outl_q;
  assign res_o.outside_mask  = omask_q;

  assign stat_o.outside   = outside_q;
  assign stat_o.samp_last = (sx_q == SS_W'(SS - 1)) && (sy_q == SS_W'(SS - 1));
  assign stat_o.nb_done   = nb_done_q;
  assign stat_o.out_free  = !out_valid_q || res_o.ready;

endmodule

>>> src/heart_mask_fill_outline_pixel.sv
// ----------------------------------------------------------------------------
// heart_mask_fill_outline_pixel: heart mask fill and outline alpha per pixel
// Supersampled heart-curve coverage and its window-minimum outline.
// ----------------------------------------------------------------------------
// Usage
//   pix_i carries one pixel coordinate per transaction; res_o returns one
//   transaction per pixel with fill_alpha, outline_alpha and outside_mask.
//   mask_size is written through cfg_we_i/cfg_data_i while the block is idle.
// Evaluation
//   One pixel at a time. Each of the 16 sub-samples runs two 34-step serial
//   divisions for its coordinates and eight passes through the single
//   shared 32x32 multiplier. The center pixel is evaluated first, then each
//   visited window neighbor: none when the center is uncovered or its
//   window crosses the image edge, else up to (2r+1)^2, stopping at a zero
//   count. The result is then loaded into the output register and the next
//   item can be taken. A pixel outside the mask skips the evaluation and
//   goes straight to the result.
// Reset
//   rst_ni clears the sequencer and the result valid, and sets mask_size to
//   48.
// Stall
//   A finished result waits in the output register; pix_i.ready returns as
//   soon as the result is loaded there, so the next pixel can start while
//   the receiver stalls.
// ----------------------------------------------------------------------------
module heart_mask_fill_outline_pixel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hmfop_pkg::SIZE_W-1:0] cfg_data_i,
  hmfop_pix_if.sink                    pix_i,
  hmfop_res_if.source                  res_o
);
  import hmfop_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  hmfop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  hmfop_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .pixel_x_i  (pix_i.pixel_x),
    .pixel_y_i  (pix_i.pixel_y),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  // Outside pixels give zero alphas
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.outside_mask |->
      res_o.fill_alpha == 8'd0 && res_o.outline_alpha == 8'd0)
    else $error("outside pixel with nonzero alpha");

  // Outline never exceeds fill
  a_outline_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.outline_alpha <= res_o.fill_alpha)
    else $error("outline alpha above fill alpha");

  // Busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> !pix_i.ready)
    else $error("ready while a pixel is in work");
`endif

endmodule

>>> verif/tb_heart_mask_fill_outline_pixel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heart_mask_fill_outline_pixel: self-checking bench for the heart mask
// pixel block. Pixels go in over the coordinate channel; each returned
// transaction is checked against a local fixed-point heart coverage model.
// Both channels idle at random; the mask size is changed between phases.
// ----------------------------------------------------------------------------
module tb_heart_mask_fill_outline_pixel;
  import hmfop_pkg::*;

  typedef struct {
    logic [7:0] fill;
    logic [7:0] outline;
    logic       outside;
  } alpha_pair_t;

  localparam longint ONE_Q = 64'sd16777216;
  localparam longint SX_Q  = 64'sd22481469;
  localparam longint SY_Q  = 64'sd21474836;
  localparam longint OY_Q  = 64'sd2348810;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  hmfop_pix_if pix ();
  hmfop_res_if res ();

  heart_mask_fill_outline_pixel dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  always #5 clk_i = ~clk_i;

  alpha_pair_t pending_alphas[$];
  int          errors = 0;
  int          hold_cycles = 0;   // receiver hold-off request
  bit          no_idle = 0;
  logic [7:0]  size_reg = 8'd48;  // mirror of mask_size

  // ---------------- coverage model ----------------
  function automatic longint qmul(longint a, longint b);
    return (a * b) / ONE_Q;
  endfunction

  function automatic longint sample_pos(int p, int s, int size);
    longint num;
    num = longint'(2 * SS * p + 2 * s + 1) * ONE_Q;
    return num / longint'(SS * size) - ONE_Q;
  endfunction

  function automatic int heart_hits(int px, int py, int size);
    int hits;
    longint x, y, x2, y2, a, a3, t;
    hits = 0;
    for (int sy = 0; sy < SS; sy++) begin
      y = OY_Q - qmul(sample_pos(py, sy, size), SY_Q);
      for (int sx = 0; sx < SS; sx++) begin
        x  = qmul(sample_pos(px, sx, size), SX_Q);
        x2 = qmul(x, x);
        y2 = qmul(y, y);
        a  = x2 + y2 - ONE_Q;
        a3 = qmul(qmul(a, a), a);
        t  = qmul(qmul(x2, y2), y);
        if (a3 - t < 0) hits++;
      end
    end
    return hits;
  endfunction

  function automatic logic [7:0] hits_to_alpha(int h);
    return 8'((2 * 255 * h + SS * SS) / (2 * SS * SS));
  endfunction

  function automatic alpha_pair_t predict_alphas(int px, int py, int size_cfg);
    alpha_pair_t r;
    int size, c, mn, rad, s;
    size = (size_cfg > MAX_SIZE) ? MAX_SIZE : size_cfg;
    if (px >= size || py >= size) begin
      r.fill = '0;
      r.outline = '0;
      r.outside = 1'b1;
      return r;
    end
    c = heart_hits(px, py, size);
    rad = size / 13;
    if (rad < 1) rad = 1;
    mn = c;
    // window minimum, off-image neighbors count as zero
    for (int dy = -rad; dy <= rad && mn > 0; dy++) begin
      for (int dx = -rad; dx <= rad && mn > 0; dx++) begin
        if (px + dx < 0 || py + dy < 0 || px + dx >= size || py + dy >= size)
          s = 0;
        else
          s = heart_hits(px + dx, py + dy, size);
        if (s < mn) mn = s;
      end
    end
    r.fill = hits_to_alpha(c);
    r.outline = hits_to_alpha(c - mn);
    r.outside = 1'b0;
    return r;
  endfunction

  // ---------------- helpers ----------------
  function automatic int pick_gap();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // one coordinate transaction; called and returning at a falling edge
  task automatic send_pixel(int px, int py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= 7'(px);
    pix.pixel_y <= 7'(py);
    do @(posedge clk_i); while (!pix.ready);
    pending_alphas.push_back(predict_alphas(px, py, size_reg));
    @(negedge clk_i);
  endtask

  // drain, let the block settle, then write the mask size
  task automatic set_mask_size(int value);
    pix.valid <= 1'b0;
    wait (pending_alphas.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= 8'(value);
    size_reg   = 8'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------- receiver ----------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      res.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      res.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  // result check at the rising edge
  always @(posedge clk_i) begin
    alpha_pair_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_alphas.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = pending_alphas.pop_front();
        if (res.fill_alpha !== e.fill) report_mismatch("fill_alpha", res.fill_alpha, e.fill);
        if (res.outline_alpha !== e.outline)
          report_mismatch("outline_alpha", res.outline_alpha, e.outline);
        if (res.outside_mask !== e.outside)
          report_mismatch("outside_mask", res.outside_mask, e.outside);
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_size();
    send_pixel(24, 20);
    send_pixel(0, 0);
    send_pixel(47, 47);
    send_pixel(12, 14);
    send_pixel(48, 0);
    send_pixel(0, 48);
    send_pixel(127, 127);
  endtask

  task automatic test_tiny_sizes();
    set_mask_size(0);
    send_pixel(0, 0);
    set_mask_size(1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    set_mask_size(2);
    for (int y = 0; y < 2; y++)
      for (int x = 0; x < 2; x++) send_pixel(x, y);
  endtask

  task automatic test_radius_steps();
    set_mask_size(13);
    send_pixel(6, 6);
    send_pixel(3, 4);
    send_pixel(12, 12);
    set_mask_size(26);
    send_pixel(13, 13);
    send_pixel(6, 8);
  endtask

  // large sizes: only edge and uncovered pixels, which finish fast
  task automatic test_size_clamp();
    set_mask_size(128);
    send_pixel(127, 127);
    send_pixel(2, 64);
    set_mask_size(255);
    send_pixel(0, 0);
    send_pixel(64, 3);
  endtask

  task automatic test_random_pixels();
    int size, x, y;
    for (int n = 0; n < 70; n++) begin
      if (n % 20 == 0) begin
        size = $urandom_range(3, 16);
        set_mask_size(size);
        no_idle = (n == 40);
      end
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 127);
      end else begin
        x = $urandom_range(0, size);
        y = $urandom_range(0, size);
      end
      send_pixel(x, y);
    end
    no_idle = 0;
  endtask

  // receiver stalls while outside pixels keep coming
  task automatic test_backpressure();
    set_mask_size(5);
    hold_cycles = 300;
    for (int n = 0; n < 10; n++) send_pixel(5 + n, $urandom_range(0, 127));
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    res.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_size();
    test_tiny_sizes();
    test_radius_steps();
    test_size_clamp();
    test_backpressure();
    test_random_pixels();
    pix.valid <= 1'b0;
    wait (pending_alphas.size() == 0);
    repeat (50) @(negedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/hmfop_pkg.sv
src/hmfop_if.sv
src/hmfop_ctrl.sv
src/hmfop_dp.sv
src/heart_mask_fill_outline_pixel.sv
verif/tb_heart_mask_fill_outline_pixel.sv
